// ===== rtl/core/mbrm_pkg.sv =====
// mbrm_pkg: shared types, codes and the crc-16/modbus byte update
// used by the front end, the job queue and the back end of the read-register master
// no dependencies
package mbrm_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_CRC      = 2'd3;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  QTY_HI       = 8'h00;
  localparam logic [7:0]  QTY_LO       = 8'h01;
  localparam logic [2:0]  RX_LAST      = 3'd6;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  typedef enum logic {
    JOB_REQ,
    JOB_DONE
  } job_kind_t;

  // request: data is the register address, aux the slave address
  // finish: data is the value, aux[1:0] the status
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] data;
    logic [7:0]  aux;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mbrm_front.sv =====
// mbrm_front: accepts input transactions, holds the configuration and the reply state,
// and pushes request and finish jobs into the queue; depends on mbrm_pkg
module mbrm_front import mbrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] reg_address,
  input  logic [7:0]  rx_byte,
  input  q_status_t   q_status,
  output q_push_t     q_push
);

  logic [7:0]  slave_address;
  logic [15:0] response_timeout;

  logic        waiting, waiting_next;
  logic [2:0]  rx_count, rx_count_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] value_store, value_store_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic        header_ok, header_ok_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic        accept;
  logic [1:0]  st;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    waiting_next       = waiting;
    rx_count_next      = rx_count;
    crc_acc_next       = crc_acc;
    value_store_next   = value_store;
    crc_low_seen_next  = crc_low_seen;
    header_ok_next     = header_ok;
    elapsed_ticks_next = elapsed_ticks;
    q_push.valid       = 1'b0;
    q_push.job.kind    = JOB_DONE;
    q_push.job.data    = '0;
    q_push.job.aux     = '0;
    st                 = ST_OK;
    if (!header_ok) begin
      st = ST_MISMATCH;
    end else if ({rx_byte, crc_low_seen} != crc_acc) begin
      st = ST_CRC;
    end
    if (accept) begin
      case (cmd)
        CMD_START: begin
          q_push.valid       = 1'b1;
          q_push.job.kind    = JOB_REQ;
          q_push.job.data    = reg_address;
          q_push.job.aux     = slave_address;
          waiting_next       = 1'b1;
          rx_count_next      = '0;
          crc_acc_next       = CRC_INIT;
          value_store_next   = '0;
          crc_low_seen_next  = '0;
          header_ok_next     = 1'b1;
          elapsed_ticks_next = '0;
        end
        CMD_BYTE: begin
          if (waiting) begin
            rx_count_next = rx_count + 3'd1;
            if (rx_count < 3'd5) begin
              crc_acc_next = crc_byte(crc_acc, rx_byte);
            end
            if (rx_count == 3'd0 && rx_byte != slave_address) begin
              header_ok_next = 1'b0;
            end
            if (rx_count == 3'd1 && rx_byte != FUNC_READ) begin
              header_ok_next = 1'b0;
            end
            if (rx_count == 3'd3) begin
              value_store_next[15:8] = rx_byte;
            end
            if (rx_count == 3'd4) begin
              value_store_next[7:0] = rx_byte;
            end
            if (rx_count == 3'd5) begin
              crc_low_seen_next = rx_byte;
            end
            if (rx_count >= RX_LAST) begin
              // seventh byte: check and report
              q_push.valid    = 1'b1;
              q_push.job.kind = JOB_DONE;
              q_push.job.data = (st == ST_OK) ? value_store : 16'h0000;
              q_push.job.aux  = {6'd0, st};
              waiting_next    = 1'b0;
              rx_count_next   = '0;
            end
          end
        end
        CMD_TICK: begin
          if (waiting) begin
            if (elapsed_ticks != ELAPSED_MAX) begin
              elapsed_ticks_next = elapsed_ticks + 16'd1;
            end
            if (elapsed_ticks_next >= response_timeout) begin
              q_push.valid    = 1'b1;
              q_push.job.kind = JOB_DONE;
              q_push.job.data = '0;
              q_push.job.aux  = {6'd0, ST_TIMEOUT};
              waiting_next    = 1'b0;
              rx_count_next   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= 8'd1;
      response_timeout <= 16'd1000;
      waiting          <= 1'b0;
      rx_count         <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) begin
          response_timeout <= cfg_data;
        end else begin
          slave_address <= cfg_data[7:0];
        end
      end
      waiting  <= waiting_next;
      rx_count <= rx_count_next;
    end
  end

  always_ff @(posedge clk) begin
    crc_acc       <= crc_acc_next;
    value_store   <= value_store_next;
    crc_low_seen  <= crc_low_seen_next;
    header_ok     <= header_ok_next;
    elapsed_ticks <= elapsed_ticks_next;
  end

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_START) |=> (waiting && rx_count == 3'd0))
    else $error("start did not arm the reply state");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (q_push.valid && q_push.job.kind == JOB_DONE) |=> !waiting)
    else $error("finish job pushed but still waiting");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> rx_count == 3'd0)
    else $error("reply count left over while idle");

endmodule

// ===== rtl/core/mbrm_queue.sv =====
// mbrm_queue: short job queue between the front end and the back end
// register array with head and tail pointers; depends on mbrm_pkg
module mbrm_queue import mbrm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   q_push,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t q_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push           = q_push.valid;
  assign head_job       = slots[rd_ptr];
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= q_push.job;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue fill count did not follow a push");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/core/mbrm_back.sv =====
// mbrm_back: takes jobs from the queue, expands a request into eight bytes with the crc
// worked out a byte per clock while not stalled, and drives the output register; depends on mbrm_pkg
module mbrm_back import mbrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head_job,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [15:0] read_value,
  output logic [1:0]  status
);

  logic        busy;
  logic [2:0]  idx;
  logic [15:0] crc;
  job_t        job;

  logic        load;
  logic        emit;
  logic        last_step;
  logic [7:0]  req_byte;

  assign load      = !out_valid || !out_stall;
  assign emit      = busy && load;
  assign last_step = (job.kind == JOB_DONE) || (idx == 3'd7);
  assign pop       = !q_status.empty && (!busy || (emit && last_step));

  always_comb begin
    case (idx)
      3'd0:    req_byte = job.aux;
      3'd1:    req_byte = FUNC_READ;
      3'd2:    req_byte = job.data[15:8];
      3'd3:    req_byte = job.data[7:0];
      3'd4:    req_byte = QTY_HI;
      3'd5:    req_byte = QTY_LO;
      3'd6:    req_byte = crc[7:0];
      default: req_byte = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (load) begin
        out_valid <= 1'b0;
      end
      // a new job taken as the old one ends keeps the sequencer busy
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (job.kind == JOB_REQ) begin
        kind       <= KIND_TX;
        tx_byte    <= req_byte;
        tx_last    <= (idx == 3'd7);
        read_value <= '0;
        status     <= ST_OK;
      end else begin
        kind       <= KIND_DONE;
        tx_byte    <= '0;
        tx_last    <= 1'b0;
        read_value <= job.data;
        status     <= job.aux[1:0];
      end
    end
    if (pop) begin
      job <= head_job;
      idx <= '0;
      crc <= CRC_INIT;
    end else if (emit && job.kind == JOB_REQ) begin
      if (idx < 3'd6) begin
        crc <= crc_byte(crc, req_byte);
      end
      idx <= idx + 3'd1;
    end
  end

  a_last_is_tx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_last) |-> kind == KIND_TX)
    else $error("last-byte flag on a finish transaction");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DONE) |-> (tx_byte == 8'h00 && !tx_last))
    else $error("finish transaction carries request byte fields");

  a_req_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && job.kind == JOB_REQ && idx == 3'd7 && q_status.empty) |=> !busy)
    else $error("request did not end after its eighth byte");

endmodule

// ===== rtl/core/modbus_rtu_read_register_master_top.sv =====
// modbus_rtu_read_register_master_top: top level of the read-register master
// ties front end, job queue and back end together; depends on mbrm_pkg and the three sub-blocks
//
// modbus rtu master for one read holding register (function 0x03) at a time. an input
// transaction with cmd start sends the slave address, 0x03, the register address high and
// low, 0x00, 0x01 and the crc-16/modbus low and high bytes as eight output transactions
// of kind 0, tx_last marking the eighth. received bytes (cmd 1) and millisecond ticks
// (cmd 2) then feed the reply check; the seventh reply byte or a timeout gives one output
// transaction of kind 1 with read_value and status (0 ok, 1 timeout, 2 address or function
// mismatch, 3 crc mismatch; mismatch wins over crc). bytes and ticks while idle are
// dropped, cmd 3 is ignored, and a start while waiting abandons the old reply silently.
// rate: an input transaction is accepted every clock while the job queue has room
// (QUEUE_DEPTH jobs); the back end delivers one output transaction a clock while
// out_stall is low, so a request occupies it for eight output transactions and a finish
// for one. the queue slot is loaded at the accepting edge, then the job register, and
// then the output register, from which the first request byte shows at the output.
// configuration is written through cfg_we / cfg_index / cfg_data while the block is idle:
// index 0 slave_address (reset 1), index 1 response_timeout in ticks (reset 1000).
module modbus_rtu_read_register_master_top import mbrm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] reg_address,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [15:0] read_value,
  output logic [1:0]  status
);

  q_push_t   q_push;
  q_status_t q_status;
  job_t      head_job;
  logic      pop;

  // front end: classifies transactions, owns the reply and timeout state
  mbrm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .reg_address (reg_address),
    .rx_byte     (rx_byte),
    .q_status    (q_status),
    .q_push      (q_push)
  );

  // jobs in order, so results keep the order of the transactions that caused them
  mbrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // back end: request byte sequencer and output register
  mbrm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .tx_last    (tx_last),
    .read_value (read_value),
    .status     (status)
  );

endmodule
